// ===== hw/rtl/drm_pkg.sv =====
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types and constants of the duet register machine execute core:
// opcodes, request and result structs, and the iterative unit's command.
// ----------------------------------------------------------------------------
package drm_pkg;

  // Default sizing of the machine
  localparam int NUM_REGS_DEF = 26;
  localparam int PC_BITS_DEF  = 32;

  // Register p, loaded from the program id
  localparam logic [4:0] P_INDEX = 5'd15;

  // Opcodes
  localparam logic [2:0] OP_SND = 3'd0;
  localparam logic [2:0] OP_SET = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_JGZ = 3'd5;
  localparam logic [2:0] OP_RCV = 3'd6;

  // Configuration register indexes
  localparam logic REG_PROGRAM_ID = 1'b0;

  // One decoded instruction request
  typedef struct packed {
    logic [2:0]         func;
    logic [4:0]         x_reg;
    logic               x_is_imm;
    logic signed [63:0] x_imm;
    logic               y_is_imm;
    logic [4:0]         y_reg;
    logic signed [63:0] y_imm;
    logic               rx_valid;
    logic signed [63:0] rx_value;
  } drm_in_t;

  // One execution result
  typedef struct packed {
    logic signed [31:0] next_pc;
    logic               send_valid;
    logic signed [63:0] send_value;
    logic               rx_taken;
    logic               stalled;
    logic               divide_by_zero;
    logic [31:0]        sends_so_far;
  } drm_out_t;

  // Operations of the shared iterative unit
  typedef enum logic [1:0] {
    IOP_ADD,
    IOP_MUL,
    IOP_REM
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_cmd_t;

endpackage

// ===== hw/rtl/drm_ram.sv =====
// ----------------------------------------------------------------------------
// drm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module drm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 26,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/drm_iter.sv =====
// ----------------------------------------------------------------------------
// drm_iter
// Shared iterative arithmetic unit: one 64-bit adder/subtractor used for
// add, shift-add multiply and restoring truncated remainder.
// ----------------------------------------------------------------------------
module drm_iter (
  input  logic              clk,
  input  logic              rst_n,
  input  drm_pkg::iter_cmd_t cmd,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [63:0]       result
);
  import drm_pkg::*;

  typedef enum logic [2:0] {
    I_IDLE,
    I_SUM,
    I_ABSA,
    I_ABSB,
    I_LOOP,
    I_FIX,
    I_DONE
  } istate_t;

  istate_t     state_r;
  iter_op_t    op_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc_r;
  logic [5:0]  cnt_r;
  logic        neg_r;

  logic [63:0] add_x;
  logic [63:0] add_y;
  logic        sub;
  logic [64:0] sum;
  logic [63:0] rem_sh;
  logic        last;

  assign rem_sh = {acc_r[62:0], a_r[63]};
  assign last   = (cnt_r == 6'd63);

  // Route operands onto the shared adder
  always_comb begin
    add_x = a_r;
    add_y = b_r;
    sub   = 1'b0;
    unique case (state_r)
      I_ABSA: begin
        add_x = '0;
        add_y = a_r;
        sub   = 1'b1;
      end
      I_ABSB: begin
        add_x = '0;
        add_y = b_r;
        sub   = 1'b1;
      end
      I_LOOP: begin
        if (op_r == IOP_MUL) begin
          add_x = acc_r;
          add_y = a_r;
        end else begin
          add_x = rem_sh;
          add_y = b_r;
          sub   = 1'b1;
        end
      end
      I_FIX: begin
        add_x = '0;
        add_y = acc_r;
        sub   = 1'b1;
      end
      default: begin
        add_x = a_r;
        add_y = b_r;
        sub   = 1'b0;
      end
    endcase
  end

  // Carry out high on a subtraction means no borrow
  assign sum = {1'b0, add_x} + {1'b0, (sub ? ~add_y : add_y)} + 65'(sub);

  assign done   = (state_r == I_DONE);
  assign result = acc_r;

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= I_IDLE;
    end else begin
      unique case (state_r)
        I_IDLE: begin
          if (cmd.start) begin
            op_r  <= cmd.op;
            a_r   <= a;
            b_r   <= b;
            acc_r <= '0;
            cnt_r <= '0;
            neg_r <= a[63];
            unique case (cmd.op)
              IOP_ADD: state_r <= I_SUM;
              IOP_MUL: state_r <= I_LOOP;
              IOP_REM: state_r <= I_ABSA;
              default: state_r <= I_SUM;
            endcase
          end
        end
        I_SUM: begin
          acc_r   <= sum[63:0];
          state_r <= I_DONE;
        end
        I_ABSA: begin
          if (a_r[63]) begin
            a_r <= sum[63:0];
          end
          state_r <= I_ABSB;
        end
        I_ABSB: begin
          if (b_r[63]) begin
            b_r <= sum[63:0];
          end
          state_r <= I_LOOP;
        end
        I_LOOP: begin
          if (op_r == IOP_MUL) begin
            // Shift-add one multiplier bit a cycle
            if (b_r[0]) begin
              acc_r <= sum[63:0];
            end
            a_r <= {a_r[62:0], 1'b0};
            b_r <= {1'b0, b_r[63:1]};
          end else begin
            // Restoring step: keep the difference when it did not borrow
            acc_r <= sum[64] ? sum[63:0] : rem_sh;
            a_r   <= {a_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (last) begin
            state_r <= (op_r == IOP_REM) ? I_FIX : I_DONE;
          end
        end
        I_FIX: begin
          // Remainder takes the sign of the dividend
          if (neg_r) begin
            acc_r <= sum[63:0];
          end
          state_r <= I_DONE;
        end
        I_DONE: begin
          state_r <= I_IDLE;
        end
        default: begin
          state_r <= I_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/duet_register_machine_execute_core.sv =====
// ----------------------------------------------------------------------------
// duet_register_machine_execute_core
// Executes one decoded duet instruction per request against a register file,
// a program counter and a send counter.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready/in_data, one decoded instruction
//   each; every request gives exactly one result on out_valid/out_ready/
//   out_data. in_ready is high only while the sequencer is idle, so one
//   request is worked on at a time.
//   After acceptance, the X and then the Y register is read through the
//   single read port of the register RAM. add, mul and mod with a nonzero
//   divisor then run on the shared adder, which takes one operand bit per
//   cycle for mul and mod; snd, set, jgz, rcv, mod with a zero divisor and
//   the unused opcode skip it.
//   The next request is accepted in the cycle after a result is loaded.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. A request that completes while the previous
//   result is still held waits in its final state until the receiver takes
//   it. Register writes and pc/counter updates happen as the result is
//   loaded.
//   Reset clears the pc, the send counter, the program id and marks every
//   register as zero through per-register valid bits, with no clearing pass.
//   The program id is written over the APB-style cfg_ port and also loads
//   register p; the user must write it only while idle (not enforced).
// ----------------------------------------------------------------------------
module duet_register_machine_execute_core #(
  parameter int NUM_REGS = drm_pkg::NUM_REGS_DEF,
  parameter int PC_BITS  = drm_pkg::PC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  drm_pkg::drm_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output drm_pkg::drm_out_t out_data,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import drm_pkg::*;

  localparam int         AW    = $clog2(NUM_REGS);
  localparam logic [4:0] NREG5 = 5'(NUM_REGS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDX,
    S_RDY,
    S_CAPY,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  state_t               state_r;
  drm_in_t              req_r;
  logic                 rd_ok_r;
  logic [63:0]          rv_r;
  logic [63:0]          yv_r;
  logic [PC_BITS-1:0]   pc_r;
  logic [PC_BITS-1:0]   pc_upd_r;
  logic [31:0]          send_cnt_r;
  logic                 wr_en_r;
  logic [63:0]          wr_val_r;
  logic                 snd_r;
  logic [63:0]          send_val_r;
  logic                 taken_r;
  logic                 stall_r;
  logic                 dz_r;
  logic [NUM_REGS-1:0]  vld_r;
  logic [7:0]           pid_r;
  logic                 out_valid_r;
  drm_out_t             out_r;

  logic                 cfg_wr;
  logic                 x_in;
  logic                 y_in;
  logic [AW-1:0]        raddr;
  logic                 rd_in;
  logic [63:0]          ram_rdata;
  logic [63:0]          rd_val;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [63:0]          ram_wdata;
  logic [63:0]          xv;
  logic                 jgz_take;
  logic [PC_BITS-1:0]   pc_inc;
  logic [PC_BITS-1:0]   pc_jmp;
  logic                 done_fire;
  logic [31:0]          send_cnt_nxt;
  logic                 wr_en_nxt;
  logic [63:0]          wr_val_nxt;
  logic                 snd_nxt;
  logic [63:0]          send_val_nxt;
  logic                 taken_nxt;
  logic                 stall_nxt;
  logic                 dz_nxt;
  logic [PC_BITS-1:0]   pc_upd_nxt;
  iter_cmd_t            iter_cmd;
  logic                 iter_done;
  logic [63:0]          iter_result;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_PROGRAM_ID);
  assign cfg_prdata = (cfg_paddr[2] == REG_PROGRAM_ID) ? {24'd0, pid_r} : 32'd0;

  // Register index checks and read address
  assign x_in  = (req_r.x_reg < NREG5);
  assign y_in  = (req_r.y_reg < NREG5);
  assign raddr = (state_r == S_RDX) ? req_r.x_reg[AW-1:0] : req_r.y_reg[AW-1:0];
  assign rd_in = (state_r == S_RDX) ? x_in : y_in;

  // Unwritten or out-of-range registers read as zero
  assign rd_val = rd_ok_r ? ram_rdata : 64'd0;

  // Operand values and pc candidates
  assign xv       = req_r.x_is_imm ? req_r.x_imm : rv_r;
  assign jgz_take = !xv[63] && (xv != 64'd0);
  assign pc_inc   = pc_r + PC_BITS'(1);
  assign pc_jmp   = pc_r + yv_r[PC_BITS-1:0];

  assign done_fire    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign send_cnt_nxt = send_cnt_r + 32'(snd_r);

  // Register RAM write: configuration first, else the commit of a result
  always_comb begin
    if (cfg_wr) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(P_INDEX);
      ram_wdata = {56'd0, cfg_pwdata[7:0]};
    end else begin
      ram_we    = done_fire && wr_en_r && x_in;
      ram_waddr = req_r.x_reg[AW-1:0];
      ram_wdata = wr_val_r;
    end
  end

  // Start the shared unit for add, mul and mod with a nonzero divisor
  always_comb begin
    iter_cmd.start = 1'b0;
    iter_cmd.op    = IOP_ADD;
    if (state_r == S_EXEC) begin
      case (req_r.func)
        OP_ADD: begin
          iter_cmd.start = 1'b1;
          iter_cmd.op    = IOP_ADD;
        end
        OP_MUL: begin
          iter_cmd.start = 1'b1;
          iter_cmd.op    = IOP_MUL;
        end
        OP_MOD: begin
          iter_cmd.start = (yv_r != 64'd0);
          iter_cmd.op    = IOP_REM;
        end
        default: begin
          iter_cmd.start = 1'b0;
          iter_cmd.op    = IOP_ADD;
        end
      endcase
    end
  end

  // Decode the executed instruction into its flags, write and next pc
  always_comb begin
    wr_en_nxt    = 1'b0;
    wr_val_nxt   = yv_r;
    snd_nxt      = 1'b0;
    send_val_nxt = '0;
    taken_nxt    = 1'b0;
    stall_nxt    = 1'b0;
    dz_nxt       = 1'b0;
    pc_upd_nxt   = pc_inc;
    case (req_r.func) inside
      OP_SND: begin
        snd_nxt      = 1'b1;
        send_val_nxt = xv;
      end
      OP_SET: begin
        wr_en_nxt = 1'b1;
      end
      OP_ADD, OP_MUL: begin
        wr_en_nxt = 1'b1;
      end
      OP_MOD: begin
        if (yv_r == 64'd0) begin
          dz_nxt = 1'b1;
        end else begin
          wr_en_nxt = 1'b1;
        end
      end
      OP_JGZ: begin
        if (jgz_take) begin
          pc_upd_nxt = pc_jmp;
        end
      end
      OP_RCV: begin
        if (req_r.rx_valid) begin
          wr_en_nxt  = 1'b1;
          wr_val_nxt = req_r.rx_value;
          taken_nxt  = 1'b1;
        end else begin
          stall_nxt  = 1'b1;
          pc_upd_nxt = pc_r;
        end
      end
      default: begin
        wr_en_nxt = 1'b0;
      end
    endcase
  end

  drm_ram #(
    .WIDTH (64),
    .DEPTH (NUM_REGS),
    .AW    (AW)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  drm_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (iter_cmd),
    .a      (rv_r),
    .b      (yv_r),
    .done   (iter_done),
    .result (iter_result)
  );

  // Sequencer, architectural state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      send_cnt_r  <= '0;
      vld_r       <= '0;
      pid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Mark written registers as holding data
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (cfg_wr) begin
        pid_r <= cfg_pwdata[7:0];
      end

      // Raise a result as it is loaded, drop it once taken
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_RDX;
          end
        end
        S_RDX: begin
          rd_ok_r <= rd_in && vld_r[raddr];
          state_r <= S_RDY;
        end
        S_RDY: begin
          rv_r    <= rd_val;
          rd_ok_r <= rd_in && vld_r[raddr];
          state_r <= S_CAPY;
        end
        S_CAPY: begin
          yv_r    <= req_r.y_is_imm ? req_r.y_imm : rd_val;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          wr_en_r    <= wr_en_nxt;
          wr_val_r   <= wr_val_nxt;
          snd_r      <= snd_nxt;
          send_val_r <= send_val_nxt;
          taken_r    <= taken_nxt;
          stall_r    <= stall_nxt;
          dz_r       <= dz_nxt;
          pc_upd_r   <= pc_upd_nxt;
          state_r    <= iter_cmd.start ? S_WAIT : S_DONE;
        end
        S_WAIT: begin
          if (iter_done) begin
            wr_val_r <= iter_result;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            pc_r                 <= pc_upd_r;
            send_cnt_r           <= send_cnt_nxt;
            out_r.next_pc        <= 32'($signed(pc_upd_r));
            out_r.send_valid     <= snd_r;
            out_r.send_value     <= send_val_r;
            out_r.rx_taken       <= taken_r;
            out_r.stalled        <= stall_r;
            out_r.divide_by_zero <= dz_r;
            out_r.sends_so_far   <= send_cnt_nxt;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/drm_execute_chk.sv =====
// ----------------------------------------------------------------------------
// drm_execute_chk
// Port-level checks on the execute core, attached by a bind statement.
// ----------------------------------------------------------------------------
module drm_execute_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input drm_pkg::drm_out_t out_data
);
  import drm_pkg::*;

  // One request at a time: ready drops once a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a request was accepted");

  // A stalled rcv neither sends nor consumes
  a_stall_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.stalled) |->
      (!out_data.rx_taken && !out_data.send_valid && !out_data.divide_by_zero))
    else $error("stalled result carries other activity");

  // No send means a zero send value
  a_send_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.send_valid) |-> (out_data.send_value == 64'd0))
    else $error("send_value nonzero without send_valid");

  // A held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind duet_register_machine_execute_core drm_execute_chk u_drm_execute_chk (.*);

// ===== bench/duet_register_machine_execute_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duet_register_machine_execute_core_tb
// Self-checking bench for the duet execute core. Every accepted request runs
// through a model of the register file, pc and send counter. Each result is
// compared field by field with the oldest prediction. Directed requests cover
// every opcode and the corner cases. Random phases follow under several
// program ids, most with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module duet_register_machine_execute_core_tb;
  import drm_pkg::*;

  localparam logic [2:0]  OP_NOP         = 3'd7;
  localparam int          NREGS          = NUM_REGS_DEF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 80;
  localparam logic [63:0] V_MAX          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] V_MIN          = 64'h8000_0000_0000_0000;
  localparam logic [63:0] V_NEG1         = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  drm_in_t     in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  drm_out_t    out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Machine state as the bench sees it
  logic [63:0] mach_regs [NREGS];
  logic [31:0] mach_pc;
  logic [31:0] mach_sends;

  drm_out_t    pending_results [$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          tx_bursty    = 1'b1;
  bit          rx_stalling  = 1'b1;
  bit          valid_held   = 1'b0;
  int          burst_left   = 0;
  int          rx_left      = 0;

  duet_register_machine_execute_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Register file access; indexes past the file read zero and drop writes
  function automatic logic [63:0] reg_value(logic [4:0] idx);
    return (idx < NREGS) ? mach_regs[idx] : 64'd0;
  endfunction

  function automatic void reg_store(logic [4:0] idx, logic [63:0] v);
    if (idx < NREGS) mach_regs[idx] = v;
  endfunction

  // Truncated remainder: sign follows the dividend
  function automatic logic [63:0] trunc_remainder(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] r;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    r  = ma % mb;
    return a[63] ? 64'd0 - r : r;
  endfunction

  // Execute one instruction on the bench state and return its result
  function automatic drm_out_t execute_instr(drm_in_t req);
    drm_out_t    res;
    logic [63:0] xv;
    logic [63:0] yv;
    logic [63:0] rv;
    logic [31:0] pc;
    res = '0;
    xv  = req.x_is_imm ? req.x_imm : reg_value(req.x_reg);
    yv  = req.y_is_imm ? req.y_imm : reg_value(req.y_reg);
    rv  = reg_value(req.x_reg);
    pc  = mach_pc + 32'd1;
    case (req.func)
      OP_SND: begin
        res.send_valid = 1'b1;
        res.send_value = xv;
        mach_sends     = mach_sends + 32'd1;
      end
      OP_SET: reg_store(req.x_reg, yv);
      OP_ADD: reg_store(req.x_reg, rv + yv);
      OP_MUL: reg_store(req.x_reg, rv * yv);
      OP_MOD: begin
        if (yv == 64'd0) res.divide_by_zero = 1'b1;
        else reg_store(req.x_reg, trunc_remainder(rv, yv));
      end
      OP_JGZ: begin
        if ($signed(xv) > 64'sd0) pc = mach_pc + yv[31:0];
      end
      OP_RCV: begin
        if (req.rx_valid) begin
          reg_store(req.x_reg, req.rx_value);
          res.rx_taken = 1'b1;
        end else begin
          res.stalled = 1'b1;
          pc          = mach_pc;
        end
      end
      default: ;
    endcase
    mach_pc          = pc;
    res.next_pc      = pc;
    res.sends_so_far = mach_sends;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    drm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", want.next_pc, out_data.next_pc);
        check_field("send_valid", want.send_valid, out_data.send_valid);
        check_field("send_value", want.send_value, out_data.send_value);
        check_field("rx_taken", want.rx_taken, out_data.rx_taken);
        check_field("stalled", want.stalled, out_data.stalled);
        check_field("divide_by_zero", want.divide_by_zero, out_data.divide_by_zero);
        check_field("sends_so_far", want.sends_so_far, out_data.sends_so_far);
      end
    end
  end

  // Stall the receiver in runs of random length
  always @(posedge clk) begin
    if (!rx_stalling) begin
      out_ready <= 1'b1;
    end else if (rx_left == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        rx_left   <= $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b1;
        rx_left   <= $urandom_range(1, 25);
      end
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("duet_register_machine_execute_core_tb NOT OK");
      $finish;
    end
  end

  // Send one request and predict its result; drop valid between bursts
  task automatic issue(drm_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), execute_instr(req));
    valid_held = 1'b1;
    if (tx_bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid   <= 1'b0;
        valid_held  = 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        burst_left  = $urandom_range(1, 12);
      end
    end
  endtask

  // Hold off requests until every result is in and the sequencer is free
  task automatic await_idle();
    if (valid_held) begin
      in_valid   <= 1'b0;
      valid_held  = 1'b0;
    end
    while (pending_results.size() != 0 || !in_ready) @(posedge clk);
  endtask

  // Write the program id over the config port; it also loads register p
  task automatic program_id_write(logic [7:0] pid);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_PROGRAM_ID, 2'b00};
    cfg_pwdata  <= {24'd0, pid};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    reg_store(P_INDEX, {56'd0, pid});
  endtask

  function automatic drm_in_t instr(logic [2:0] f, logic [4:0] xr, logic xi,
                                    logic [63:0] xv, logic yi, logic [4:0] yr,
                                    logic [63:0] yv, logic rv, logic [63:0] rval);
    drm_in_t r;
    r.func     = f;
    r.x_reg    = xr;
    r.x_is_imm = xi;
    r.x_imm    = xv;
    r.y_is_imm = yi;
    r.y_reg    = yr;
    r.y_imm    = yv;
    r.rx_valid = rv;
    r.rx_value = rval;
    return r;
  endfunction

  // Mostly a few live registers and p, now and then any index
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
    if ($urandom_range(0, 4) == 0) return P_INDEX;
    return 5'($urandom_range(0, 5));
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return 64'($urandom_range(0, 16)) - 64'd8;
      1:       return V_MAX;
      2:       return V_MIN;
      3:       return V_NEG1;
      4:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic drm_in_t random_request();
    drm_in_t r;
    r.func     = 3'($urandom_range(0, 7));
    r.x_reg    = pick_reg();
    r.x_is_imm = 1'($urandom_range(0, 1));
    r.x_imm    = pick_value();
    r.y_is_imm = 1'($urandom_range(0, 1));
    r.y_reg    = pick_reg();
    r.y_imm    = pick_value();
    r.rx_valid = ($urandom_range(0, 3) != 0);
    r.rx_value = pick_value();
    return r;
  endfunction

  // Registers and counters straight out of reset
  task automatic test_reset_values();
    issue(instr(OP_SND, P_INDEX, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0));
    issue(instr(OP_JGZ, 5'd0, 1'b0, '0, 1'b1, '0, 64'd9, 1'b0, '0));
  endtask

  // One pass over every opcode with the top program id
  task automatic test_each_opcode();
    await_idle();
    program_id_write(8'd255);
    issue(instr(OP_SND, P_INDEX, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0));
    issue(instr(OP_SET, 5'd0, 1'b0, '0, 1'b1, '0, V_MAX, 1'b0, '0));
    issue(instr(OP_ADD, 5'd0, 1'b0, '0, 1'b1, '0, 64'd1, 1'b0, '0));
    issue(instr(OP_SET, 5'd1, 1'b0, '0, 1'b1, '0, V_NEG1, 1'b0, '0));
    issue(instr(OP_MUL, 5'd0, 1'b0, '0, 1'b0, 5'd1, '0, 1'b0, '0));
    // most negative dividend over -1
    issue(instr(OP_MOD, 5'd0, 1'b0, '0, 1'b0, 5'd1, '0, 1'b0, '0));
    issue(instr(OP_JGZ, 5'd0, 1'b1, 64'd1, 1'b1, '0, 64'd5, 1'b0, '0));
    issue(instr(OP_RCV, 5'd2, 1'b0, '0, 1'b0, '0, '0, 1'b1, V_MIN));
    issue(instr(OP_SND, 5'd2, 1'b1, V_MIN, 1'b0, '0, '0, 1'b0, '0));
  endtask

  // Corner cases with program id zero
  task automatic test_special_cases();
    await_idle();
    program_id_write(8'd0);
    // out-of-range index: write dropped, read as zero
    issue(instr(OP_SET, 5'd31, 1'b0, '0, 1'b1, '0, 64'd5, 1'b0, '0));
    issue(instr(OP_SND, 5'd31, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0));
    // immediate X is ignored by a writing opcode
    issue(instr(OP_SET, 5'd5, 1'b1, 64'd99, 1'b1, '0, 64'd42, 1'b0, '0));
    issue(instr(OP_SND, 5'd5, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0));
    // zero divisor, from a register beyond the file and from an immediate
    issue(instr(OP_MOD, 5'd5, 1'b0, '0, 1'b0, 5'd30, '0, 1'b0, '0));
    issue(instr(OP_MOD, 5'd5, 1'b0, '0, 1'b1, '0, 64'd0, 1'b0, '0));
    issue(instr(OP_SET, 5'd6, 1'b0, '0, 1'b1, '0, 64'hFFFF_FFFF_FFFF_FFF9, 1'b0, '0));
    issue(instr(OP_MOD, 5'd6, 1'b0, '0, 1'b1, '0, 64'd3, 1'b0, '0));
    issue(instr(OP_MOD, 5'd5, 1'b0, '0, 1'b1, '0, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, '0));
    // unused opcode
    issue(instr(OP_NOP, 5'd31, 1'b1, V_NEG1, 1'b1, 5'd31, V_NEG1, 1'b1, V_NEG1));
    // jgz: negative X, then pc wrap both ways
    issue(instr(OP_JGZ, 5'd0, 1'b1, V_MIN, 1'b1, '0, 64'd9, 1'b0, '0));
    issue(instr(OP_JGZ, 5'd0, 1'b1, V_MAX, 1'b1, '0, V_MAX, 1'b0, '0));
    issue(instr(OP_JGZ, 5'd5, 1'b0, '0, 1'b1, '0, 64'h0000_0000_8000_0000, 1'b0, '0));
    // rcv takes a zero value, then stalls with nothing offered
    issue(instr(OP_RCV, 5'd6, 1'b0, '0, 1'b0, '0, '0, 1'b1, 64'd0));
    issue(instr(OP_RCV, 5'd6, 1'b0, '0, 1'b0, '0, '0, 1'b0, V_NEG1));
    issue(instr(OP_SND, 5'd6, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0));
  endtask

  // Random requests under one program id; pause for a full drain now and then
  task automatic test_random_phase(logic [7:0] pid, bit idling, int count);
    await_idle();
    program_id_write(pid);
    tx_bursty   = idling;
    rx_stalling = idling;
    burst_left  = $urandom_range(1, 12);
    for (int n = 0; n < count; n++) begin
      issue(random_request());
      if (n == count / 2 || $urandom_range(0, 79) == 0) await_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < NREGS; i++) mach_regs[i] = 64'd0;
    mach_pc    = 32'd0;
    mach_sends = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_each_opcode();
    test_special_cases();
    test_random_phase(8'd255, 1'b1, 180);
    test_random_phase(8'($urandom_range(1, 254)), 1'b1, 190);
    test_random_phase(8'd0, 1'b0, 150);
    test_random_phase(8'($urandom_range(1, 254)), 1'b1, 200);

    // Drain, then watch for stray results
    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("duet_register_machine_execute_core_tb OK");
    else
      $display("duet_register_machine_execute_core_tb NOT OK");
    $finish;
  end

endmodule
